>>> design/dsu_pkg.sv
`timescale 1ns / 1ps
package dsu_pkg;

  localparam int NODE_W        = 10;
  localparam int COUNT_W       = 11;
  localparam int DEF_MAX_NODES = 1024;
  localparam int RESET_NODES   = 1024;

  typedef logic [COUNT_W-1:0] count_t;

  // zero reads as one, anything above the table depth reads as the depth
  function automatic count_t clamp_count(count_t v, int unsigned max_n);
    count_t r;
    if (v == '0) begin
      r = count_t'(1);
    end else if (32'(v) > max_n) begin
      r = count_t'(max_n);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/dsu_ram.sv
`timescale 1ns / 1ps
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/dsu_ctrl.sv
`timescale 1ns / 1ps
module dsu_ctrl #(
  parameter int MAX_NODES = dsu_pkg::DEF_MAX_NODES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_load,
  input  logic [dsu_pkg::COUNT_W-1:0]  cfg_count,
  input  logic [dsu_pkg::COUNT_W-1:0]  node_count,
  input  logic                         start,
  input  logic                         action,
  input  logic [dsu_pkg::NODE_W-1:0]   node_a,
  input  logic [dsu_pkg::NODE_W-1:0]   node_b,
  output logic                         busy,
  output logic                         done,
  output logic [dsu_pkg::NODE_W-1:0]   root_a,
  output logic [dsu_pkg::NODE_W-1:0]   root_b,
  output logic                         same_set,
  output logic                         merged,
  output logic [dsu_pkg::COUNT_W-1:0]  set_size,
  output logic [dsu_pkg::COUNT_W-1:0]  component_count,
  output logic                         index_error,
  // parent table port
  output logic                         p_we,
  output logic [$clog2(MAX_NODES)-1:0] p_waddr,
  output logic [$clog2(MAX_NODES)-1:0] p_wdata,
  output logic [$clog2(MAX_NODES)-1:0] p_raddr,
  input  logic [$clog2(MAX_NODES)-1:0] p_rdata,
  // size table port
  output logic                         s_we,
  output logic [$clog2(MAX_NODES)-1:0] s_waddr,
  output logic [dsu_pkg::COUNT_W-1:0]  s_wdata,
  output logic [$clog2(MAX_NODES)-1:0] s_raddr,
  input  logic [dsu_pkg::COUNT_W-1:0]  s_rdata
);
  import dsu_pkg::*;

  localparam int AW = $clog2(MAX_NODES);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_FIND_A = 4'd2;
  localparam logic [3:0] ST_COMP_A = 4'd3;
  localparam logic [3:0] ST_FIND_B = 4'd4;
  localparam logic [3:0] ST_COMP_B = 4'd5;
  localparam logic [3:0] ST_SIZE   = 4'd6;
  localparam logic [3:0] ST_UPDATE = 4'd7;

  logic [3:0]   state, state_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] cur, cur_next;
  logic [AW-1:0] node_a_q, node_b_q;
  logic          act_q;
  logic [AW-1:0] root_a_q, root_b_q;
  count_t        size_a_q;
  count_t        set_total;

  logic          accept, in_range;
  logic          same, do_merge;
  logic [AW-1:0] lo, hi;
  count_t        sum;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign in_range = (count_t'(node_a) < node_count) && (count_t'(node_b) < node_count);

  assign same     = (root_a_q == root_b_q);
  assign do_merge = act_q && !same;
  assign lo       = (root_a_q < root_b_q) ? root_a_q : root_b_q;
  assign hi       = (root_a_q < root_b_q) ? root_b_q : root_a_q;
  assign sum      = size_a_q + s_rdata;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    p_we       = 1'b0;
    p_waddr    = cur;
    p_wdata    = root_a_q;
    p_raddr    = cur;
    s_we       = 1'b0;
    s_waddr    = lo;
    s_wdata    = sum;
    s_raddr    = root_a_q;
    unique case (state)
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_addr;
        p_wdata = clr_addr;
        s_we    = 1'b1;
        s_waddr = clr_addr;
        s_wdata = count_t'(1);
        if (clr_addr == AW'(MAX_NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_range) begin
          p_raddr    = AW'(node_a);
          cur_next   = AW'(node_a);
          state_next = ST_FIND_A;
        end
      end
      ST_FIND_A: begin
        if (p_rdata == cur) begin
          p_raddr    = node_a_q;
          cur_next   = node_a_q;
          state_next = ST_COMP_A;
        end else begin
          p_raddr  = p_rdata;
          cur_next = p_rdata;
        end
      end
      ST_COMP_A: begin
        if (cur == root_a_q) begin
          p_raddr    = node_b_q;
          cur_next   = node_b_q;
          state_next = ST_FIND_B;
        end else begin
          // point this node at the root while fetching the next link
          p_we     = 1'b1;
          p_waddr  = cur;
          p_wdata  = root_a_q;
          p_raddr  = p_rdata;
          cur_next = p_rdata;
        end
      end
      ST_FIND_B: begin
        if (p_rdata == cur) begin
          p_raddr    = node_b_q;
          cur_next   = node_b_q;
          state_next = ST_COMP_B;
        end else begin
          p_raddr  = p_rdata;
          cur_next = p_rdata;
        end
      end
      ST_COMP_B: begin
        if (cur == root_b_q) begin
          // size of root a is fetched on the way out
          state_next = ST_SIZE;
        end else begin
          p_we     = 1'b1;
          p_waddr  = cur;
          p_wdata  = root_b_q;
          p_raddr  = p_rdata;
          cur_next = p_rdata;
        end
      end
      ST_SIZE: begin
        s_raddr    = root_b_q;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (do_merge) begin
          p_we    = 1'b1;
          p_waddr = hi;
          p_wdata = lo;
          s_we    = 1'b1;
          s_waddr = lo;
          s_wdata = sum;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      set_total <= clamp_count(count_t'(RESET_NODES), MAX_NODES);
      done      <= 1'b0;
    end else if (cfg_load) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      set_total <= cfg_count;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_UPDATE && do_merge && set_total > count_t'(1)) begin
        set_total <= set_total - count_t'(1);
      end
      if (accept && !in_range) begin
        done <= 1'b1;
      end
      if (state == ST_UPDATE) begin
        done <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (accept) begin
      node_a_q <= AW'(node_a);
      node_b_q <= AW'(node_b);
      act_q    <= action;
    end
    if (state == ST_FIND_A && p_rdata == cur) begin
      root_a_q <= cur;
    end
    if (state == ST_FIND_B && p_rdata == cur) begin
      root_b_q <= cur;
    end
    if (state == ST_SIZE) begin
      size_a_q <= s_rdata;
    end
    if (accept && !in_range) begin
      root_a          <= '0;
      root_b          <= '0;
      same_set        <= 1'b0;
      merged          <= 1'b0;
      set_size        <= '0;
      component_count <= set_total;
      index_error     <= 1'b1;
    end else if (state == ST_UPDATE) begin
      root_a      <= NODE_W'(root_a_q);
      root_b      <= NODE_W'(root_b_q);
      same_set    <= same;
      merged      <= do_merge;
      set_size    <= do_merge ? sum : size_a_q;
      index_error <= 1'b0;
      if (do_merge && set_total > count_t'(1)) begin
        component_count <= set_total - count_t'(1);
      end else begin
        component_count <= set_total;
      end
    end
  end

endmodule

>>> design/disjoint_set_union_engine.sv
`timescale 1ns / 1ps
// channel   | beat marker         | payload
// ----------+---------------------+----------------------------------------------
// command   | start && !busy      | action, node_a, node_b
// result    | done (one cycle)    | root_a, root_b, same_set, merged, set_size,
//           |                     | component_count, index_error
// config    | cfg_we              | cfg_data (node_count)
//
// a command with an index at or above node_count gives its result in the next cycle
// and leaves busy low. any other command keeps busy high while the engine follows the
// parent links from node_a and then from node_b, each link once in the find walk and
// once in the compression walk over the parent table port.
// reset and every cfg write start a clearing pass over all MAX_NODES entries, busy high.
// the result strobe cannot be held off; a new command may be taken in the strobe cycle.
module disjoint_set_union_engine #(
  parameter int MAX_NODES = dsu_pkg::DEF_MAX_NODES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        action,
  input  logic [dsu_pkg::NODE_W-1:0]  node_a,
  input  logic [dsu_pkg::NODE_W-1:0]  node_b,
  output logic                        busy,
  output logic                        done,
  output logic [dsu_pkg::NODE_W-1:0]  root_a,
  output logic [dsu_pkg::NODE_W-1:0]  root_b,
  output logic                        same_set,
  output logic                        merged,
  output logic [dsu_pkg::COUNT_W-1:0] set_size,
  output logic [dsu_pkg::COUNT_W-1:0] component_count,
  output logic                        index_error,
  input  logic                        cfg_we,
  input  logic [dsu_pkg::COUNT_W-1:0] cfg_data
);
  import dsu_pkg::*;

  localparam int AW = $clog2(MAX_NODES);

  count_t        node_count;
  count_t        cfg_count;

  logic          p_we;
  logic [AW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  count_t        s_wdata, s_rdata;

  assign cfg_count = clamp_count(cfg_data, MAX_NODES);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= clamp_count(count_t'(RESET_NODES), MAX_NODES);
    end else if (cfg_we) begin
      node_count <= cfg_count;
    end
  end

  dsu_ctrl #(
    .MAX_NODES(MAX_NODES)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_load        (cfg_we),
    .cfg_count       (cfg_count),
    .node_count      (node_count),
    .start           (start),
    .action          (action),
    .node_a          (node_a),
    .node_b          (node_b),
    .busy            (busy),
    .done            (done),
    .root_a          (root_a),
    .root_b          (root_b),
    .same_set        (same_set),
    .merged          (merged),
    .set_size        (set_size),
    .component_count (component_count),
    .index_error     (index_error),
    .p_we            (p_we),
    .p_waddr         (p_waddr),
    .p_wdata         (p_wdata),
    .p_raddr         (p_raddr),
    .p_rdata         (p_rdata),
    .s_we            (s_we),
    .s_waddr         (s_waddr),
    .s_wdata         (s_wdata),
    .s_raddr         (s_raddr),
    .s_rdata         (s_rdata)
  );

  dsu_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_NODES)
  ) u_parent_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  dsu_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(MAX_NODES)
  ) u_size_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

>>> design/dsu_checker.sv
`timescale 1ns / 1ps
module dsu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        done,
  input logic [dsu_pkg::NODE_W-1:0]  root_a,
  input logic [dsu_pkg::NODE_W-1:0]  root_b,
  input logic                        same_set,
  input logic                        merged,
  input logic [dsu_pkg::COUNT_W-1:0] set_size,
  input logic [dsu_pkg::COUNT_W-1:0] component_count,
  input logic                        index_error,
  input logic                        cfg_we
);
  import dsu_pkg::*;

  // a result beat always lands back in idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // a node_count write starts the clearing pass
  assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy && !done)
    else $error("no clearing pass after node_count write");

  // a rejected command reports no roots, no size and no merge
  assert property (@(posedge clk) disable iff (rst)
      done && index_error |-> root_a == '0 && root_b == '0 && set_size == '0 && !merged
        && !same_set)
    else $error("index error beat carries data");

  // a merge joins two different sets into one of at least two nodes
  assert property (@(posedge clk) disable iff (rst)
      done && merged |-> !same_set && !index_error && set_size > count_t'(1)
        && root_a != root_b)
    else $error("inconsistent merge beat");

  // the set count never reaches zero
  assert property (@(posedge clk) disable iff (rst) done |-> component_count != '0)
    else $error("component count zero");

endmodule

bind disjoint_set_union_engine dsu_checker u_dsu_checker (.*);

>>> tb/tb_disjoint_set_union_engine.sv
`timescale 1ns / 1ps
module tb_disjoint_set_union_engine;
  import dsu_pkg::*;

  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_UNITE = 1'b1;
  localparam int   CYCLE_LIMIT = 8_000_000;
  localparam int   DEPTH = DEF_MAX_NODES;

  typedef struct packed {
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    logic              same_set;
    logic              merged;
    count_t            set_size;
    count_t            component_count;
    logic              index_error;
  } dsu_result_t;

  class dsu_scoreboard;
    logic [NODE_W-1:0] link [DEPTH];
    count_t            tally [DEPTH];
    count_t            live_nodes;
    count_t            sets_left;
    dsu_result_t       pending_q[$];
    int                errors, checked, merges, bad_index, settings;

    function new();
      set_node_count(count_t'(RESET_NODES));
    endfunction

    function void set_node_count(count_t v);
      if (v == '0) begin
        live_nodes = count_t'(1);
      end else if (int'(v) > DEPTH) begin
        live_nodes = count_t'(DEPTH);
      end else begin
        live_nodes = v;
      end
      for (int i = 0; i < DEPTH; i++) begin
        link[i]  = NODE_W'(i);
        tally[i] = count_t'(1);
      end
      sets_left = live_nodes;
      settings++;
    endfunction

    // walk to the root, then point every node on the way straight at it
    function logic [NODE_W-1:0] find_and_flatten(logic [NODE_W-1:0] x);
      logic [NODE_W-1:0] r, cur, nxt;
      r = x;
      while (link[r] != r) r = link[r];
      cur = x;
      while (cur != r) begin
        nxt = link[cur];
        link[cur] = r;
        cur = nxt;
      end
      return r;
    endfunction

    function void note(logic act, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      dsu_result_t r;
      logic [NODE_W-1:0] lo, hi;
      r = '0;
      if (a >= live_nodes || b >= live_nodes) begin
        r.component_count = sets_left;
        r.index_error = 1'b1;
        bad_index++;
      end else begin
        r.root_a = find_and_flatten(a);
        r.root_b = find_and_flatten(b);
        r.same_set = (r.root_a == r.root_b);
        if (act == ACT_UNITE && !r.same_set) begin
          lo = (r.root_a < r.root_b) ? r.root_a : r.root_b;
          hi = (r.root_a < r.root_b) ? r.root_b : r.root_a;
          link[hi] = lo;
          tally[lo] = tally[lo] + tally[hi];
          if (sets_left > 1) sets_left--;
          r.merged = 1'b1;
          r.set_size = tally[lo];
          merges++;
        end else begin
          r.set_size = tally[r.root_a];
        end
        r.component_count = sets_left;
      end
      pending_q = {pending_q, r};
    endfunction

    task log_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    task check(dsu_result_t got);
      dsu_result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        log_mismatch("result beat with no command waiting", 32'(got.root_a), 32'(0));
      end else begin
        want = pending_q.pop_front();
        if (got.root_a !== want.root_a)
          log_mismatch("root_a", 32'(got.root_a), 32'(want.root_a));
        if (got.root_b !== want.root_b)
          log_mismatch("root_b", 32'(got.root_b), 32'(want.root_b));
        if (got.same_set !== want.same_set)
          log_mismatch("same_set", 32'(got.same_set), 32'(want.same_set));
        if (got.merged !== want.merged)
          log_mismatch("merged", 32'(got.merged), 32'(want.merged));
        if (got.set_size !== want.set_size)
          log_mismatch("set_size", 32'(got.set_size), 32'(want.set_size));
        if (got.component_count !== want.component_count)
          log_mismatch("component_count", 32'(got.component_count),
                       32'(want.component_count));
        if (got.index_error !== want.index_error)
          log_mismatch("index_error", 32'(got.index_error), 32'(want.index_error));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              action = 1'b0;
  logic [NODE_W-1:0] node_a = '0;
  logic [NODE_W-1:0] node_b = '0;
  logic              cfg_we = 1'b0;
  count_t            cfg_data = '0;
  logic              busy, done, same_set, merged, index_error;
  logic [NODE_W-1:0] root_a, root_b;
  count_t            set_size, component_count;

  dsu_scoreboard sb;
  dsu_result_t   seen;
  int            cycle_count = 0;
  int            sent = 0;
  bit            steady = 1'b0;

  disjoint_set_union_engine dut (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .node_a(node_a), .node_b(node_b), .busy(busy), .done(done),
    .root_a(root_a), .root_b(root_b), .same_set(same_set), .merged(merged),
    .set_size(set_size), .component_count(component_count),
    .index_error(index_error), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_disjoint_set_union_engine: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen = {root_a, root_b, same_set, merged, set_size, component_count, index_error};
      sb.check(seen);
    end
  end

  // called at a falling edge; start stays high on return so back-to-back beats need no gap
  task automatic send_cmd(input logic act, input int a, input int b);
    int idle;
    idle = steady ? 0 : $urandom_range(0, 9);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    start  <= 1'b1;
    action <= act;
    node_a <= NODE_W'(a);
    node_b <= NODE_W'(b);
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(act, NODE_W'(a), NODE_W'(b));
    sent++;
    @(negedge clk);
  endtask

  task automatic write_node_count(input int v);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= count_t'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_node_count(count_t'(v));
  endtask

  task automatic random_cmd();
    int pick, top;
    pick = $urandom_range(0, 99);
    top  = int'(sb.live_nodes) - 1;
    if (pick < 8) begin
      // noise over the full index range, may hit the error path
      send_cmd(1'($urandom_range(0, 1)), $urandom_range(0, DEPTH - 1),
               $urandom_range(0, DEPTH - 1));
    end else begin
      send_cmd(pick < 70 ? ACT_UNITE : ACT_QUERY, $urandom_range(0, top),
               $urandom_range(0, top));
    end
  endtask

  int phase_counts[9] = '{16, 5, 1024, 40, 2, 100, 1024, 1500, 12};

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // default node count after reset
    send_cmd(ACT_QUERY, 0, 0);
    send_cmd(ACT_QUERY, 1023, 1023);
    send_cmd(ACT_UNITE, 1023, 0);
    send_cmd(ACT_UNITE, 0, 1023);
    send_cmd(ACT_UNITE, 512, 1023);
    send_cmd(ACT_QUERY, 1023, 512);
    send_cmd(ACT_UNITE, 341, 682);
    send_cmd(ACT_QUERY, 682, 0);

    // zero is taken as a single node
    write_node_count(0);
    send_cmd(ACT_QUERY, 0, 0);
    send_cmd(ACT_UNITE, 0, 0);
    send_cmd(ACT_UNITE, 1, 0);
    send_cmd(ACT_QUERY, 0, 1023);

    // above the table depth clamps to the depth
    write_node_count(2047);
    send_cmd(ACT_UNITE, 1, 2);
    send_cmd(ACT_QUERY, 2, 2);

    // two nodes: merge down to one set, then try again
    write_node_count(2);
    send_cmd(ACT_UNITE, 1, 0);
    send_cmd(ACT_UNITE, 0, 1);
    send_cmd(ACT_QUERY, 1, 1);
    send_cmd(ACT_UNITE, 2, 1);
    send_cmd(ACT_QUERY, 1023, 1023);

    // three nodes chained, then a query that walks two links
    write_node_count(3);
    send_cmd(ACT_UNITE, 2, 1);
    send_cmd(ACT_UNITE, 1, 0);
    send_cmd(ACT_QUERY, 2, 2);

    // long chain built by descending unites, then flattened by queries
    write_node_count(64);
    for (int i = 63; i >= 1; i--) send_cmd(ACT_UNITE, i, i - 1);
    send_cmd(ACT_QUERY, 63, 0);
    send_cmd(ACT_QUERY, 62, 5);
    send_cmd(ACT_UNITE, 63, 31);

    for (int p = 0; p < 9; p++) begin
      write_node_count(phase_counts[p]);
      steady = (p % 3 == 2);
      repeat (40) random_cmd();
    end
    steady = 1'b0;

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d commands over %0d node count settings, %0d result beats checked",
             sent, sb.settings, sb.checked);
    $display("of those %0d merged sets and %0d hit an out-of-range index",
             sb.merges, sb.bad_index);
    if (sb.errors == 0) begin
      $display("tb_disjoint_set_union_engine: done, clean");
    end else begin
      $display("tb_disjoint_set_union_engine: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
design/dsu_pkg.sv
design/dsu_ram.sv
design/dsu_ctrl.sv
design/disjoint_set_union_engine.sv
design/dsu_checker.sv
tb/tb_disjoint_set_union_engine.sv
